FILE: hw/rtl/gms_pkg.sv
// Shared types and constants for the grouped median selector.
package gms_pkg;

    localparam int MAX_RECORDS = 256;
    localparam int AGE_W       = 8;
    localparam int CLASS_W     = 2;
    localparam int CLASS_N     = 4;
    localparam int GROUP_N     = 7;
    localparam int GRP_W       = 3;
    localparam int ADDR_W      = $clog2(MAX_RECORDS);
    localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
    localparam int BIT_W       = $clog2(AGE_W);
    localparam int REC_W       = AGE_W + CLASS_W;

    // Bit c is set when class c = {is_male, employed} belongs to the group.
    localparam logic [CLASS_N-1:0] GROUP_CLASSES [GROUP_N] = '{
        4'hF, 4'h3, 4'hC, 4'h2, 4'h1, 4'h8, 4'h4
    };

    typedef struct packed {
        logic [AGE_W-1:0] age;
        logic             is_male;
        logic             employed;
        logic             last_record;
    } t_in;

    typedef struct packed {
        logic [GRP_W-1:0] group;
        logic [AGE_W-1:0] median_age;
        logic             truncated;
        logic             last_result;
    } t_out;

    typedef struct packed {
        logic load;
        logic init;
        logic scan;
        logic update;
        logic emit;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic addr_last;
        logic bit_last;
        logic emit_last;
        logic out_free;
    } t_status;

endpackage

FILE: hw/rtl/gms_ctrl.sv
// Sequencer for loading, radix selection passes and result emission.
module gms_ctrl
    import gms_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_last,
    input  t_status i_status,
    output logic    o_in_stall,
    output t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_LOAD,
        S_INIT,
        S_SCAN,
        S_DRAIN,
        S_UPDATE,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = (r_state != S_LOAD);
        case (r_state)
            S_LOAD: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid && i_in_last) begin
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                o_cmd.init = 1'b1;
                n_state    = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.addr_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = i_status.bit_last ? S_EMIT : S_SCAN;
            end
            S_EMIT: begin
                o_cmd.emit = i_status.out_free;
                if (i_status.out_free && i_status.emit_last) begin
                    o_cmd.clear = 1'b1;
                    n_state     = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: hw/rtl/gms_datapath.sv
// Record store, class counters, per-group radix selection and output register.
module gms_datapath
    import gms_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_in     i_in_data,
    input  logic    i_out_stall,
    input  t_cmd    i_cmd,
    output t_status o_status,
    output t_out    o_out_data,
    output logic    o_out_valid
);

    logic [REC_W-1:0] mem [MAX_RECORDS];

    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_cls_cnt [CLASS_N];
    logic               r_ovf;
    logic [ADDR_W-1:0]  r_addr;
    logic [REC_W-1:0]   r_rd_data;
    logic               r_acc_vld;
    logic [BIT_W-1:0]   r_bit;
    logic [AGE_W-1:0]   r_prefix    [GROUP_N];
    logic [CNT_W-1:0]   r_rank      [GROUP_N];
    logic [CNT_W-1:0]   r_match_cnt [GROUP_N];
    logic [GROUP_N-1:0] r_empty;
    logic [GRP_W-1:0]   r_emit_idx;
    t_out               r_out;
    logic               r_out_vld;

    logic               full;
    logic [CLASS_W-1:0] in_cls;
    logic [CNT_W-1:0]   n_sum [GROUP_N];
    logic [AGE_W-1:0]   rd_age;
    logic [CLASS_W-1:0] rd_cls;
    logic [BIT_W:0]     shift_amt;
    logic [AGE_W-1:0]   hi_mask;
    logic [GROUP_N-1:0] match;

    assign full   = (r_count >= CNT_W'(MAX_RECORDS));
    assign in_cls = {i_in_data.is_male, i_in_data.employed};
    assign rd_age = r_rd_data[REC_W-1:CLASS_W];
    assign rd_cls = r_rd_data[CLASS_W-1:0];

    assign shift_amt = {1'b0, r_bit} + 1'b1;
    assign hi_mask   = {AGE_W{1'b1}} << shift_amt;

    always_comb begin
        for (int g = 0; g < GROUP_N; g++) begin
            n_sum[g] = '0;
            for (int c = 0; c < CLASS_N; c++) begin
                if (GROUP_CLASSES[g][c]) begin
                    n_sum[g] = n_sum[g] + r_cls_cnt[c];
                end
            end
            match[g] = GROUP_CLASSES[g][rd_cls]
                       && (((rd_age ^ r_prefix[g]) & hi_mask) == '0)
                       && !rd_age[r_bit];
        end
    end

    assign o_status.addr_last = (CNT_W'(r_addr) == r_count - 1'b1);
    assign o_status.bit_last  = (r_bit == '0);
    assign o_status.emit_last = (r_emit_idx == GRP_W'(GROUP_N - 1));
    assign o_status.out_free  = !r_out_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && !full) begin
            mem[r_count[ADDR_W-1:0]] <= {i_in_data.age, in_cls};
        end
        r_rd_data <= mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_ovf      <= 1'b0;
            r_emit_idx <= '0;
            r_acc_vld  <= 1'b0;
            r_out_vld  <= 1'b0;
            for (int c = 0; c < CLASS_N; c++) begin
                r_cls_cnt[c] <= '0;
            end
        end else begin
            r_acc_vld <= i_cmd.scan;
            if (i_cmd.load) begin
                if (full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_count         <= r_count + 1'b1;
                    r_cls_cnt[in_cls] <= r_cls_cnt[in_cls] + 1'b1;
                end
            end
            if (i_cmd.emit) begin
                r_out_vld  <= 1'b1;
                r_emit_idx <= r_emit_idx + 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            if (i_cmd.clear) begin
                r_count    <= '0;
                r_ovf      <= 1'b0;
                r_emit_idx <= '0;
                for (int c = 0; c < CLASS_N; c++) begin
                    r_cls_cnt[c] <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_addr <= '0;
            r_bit  <= BIT_W'(AGE_W - 1);
            for (int g = 0; g < GROUP_N; g++) begin
                r_prefix[g]    <= '0;
                r_rank[g]      <= n_sum[g] >> 1;
                r_empty[g]     <= (n_sum[g] == '0);
                r_match_cnt[g] <= '0;
            end
        end else if (i_cmd.update) begin
            r_addr <= '0;
            r_bit  <= r_bit - 1'b1;
            for (int g = 0; g < GROUP_N; g++) begin
                if (r_rank[g] >= r_match_cnt[g]) begin
                    r_prefix[g][r_bit] <= 1'b1;
                    r_rank[g]          <= r_rank[g] - r_match_cnt[g];
                end
                r_match_cnt[g] <= '0;
            end
        end else begin
            if (i_cmd.scan) begin
                r_addr <= r_addr + 1'b1;
            end
            if (r_acc_vld) begin
                for (int g = 0; g < GROUP_N; g++) begin
                    if (match[g]) begin
                        r_match_cnt[g] <= r_match_cnt[g] + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.group       <= r_emit_idx;
            r_out.median_age  <= r_empty[r_emit_idx] ? '0 : r_prefix[r_emit_idx];
            r_out.truncated   <= r_ovf;
            r_out.last_result <= (r_emit_idx == GRP_W'(GROUP_N - 1));
        end
    end

    assign o_out_data  = r_out;
    assign o_out_valid = r_out_vld;

    // A scan never reads past the stored records.
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan |-> (CNT_W'(r_addr) < r_count))
        else $error("scan address beyond record count");

    // The record count never exceeds the store capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_RECORDS))
        else $error("record count above capacity");

    // After the final result is issued the set is empty and untruncated.
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && o_status.emit_last) |=> (r_count == '0 && !r_ovf))
        else $error("set not cleared after final result");

    // A stalled result is never overwritten by a new one.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_out_stall) |-> !i_cmd.emit)
        else $error("result overwritten while stalled");

endmodule

FILE: hw/rtl/grouped_median_selector_unit.sv
// Top level of the grouped median selector: controller and datapath.
//
// Input channel: one record per transfer (age, is_male, employed, last_record).
// Records are taken one per cycle while the block is loading. The record with
// last_record set closes the set; records past the capacity of 256 are dropped
// and the results of that set carry truncated.
// After the closing record the block stalls its input and finds the seven
// medians by a bitwise radix search over the record store: eight passes, one
// per age bit from the top, each reading the n stored records through the
// single memory read port and counting matches for all seven groups at once.
// The seven results (all, female, male, employed female, unemployed female,
// employed male, unemployed male) then leave through an output register, one
// per cycle when the receiver does not stall; a stall holds the current
// result and pauses emission. Loading of the next set resumes once the
// seventh result sits in the output register.
// Reset empties the set and clears the output valid; store contents are kept.
module grouped_median_selector_unit
    import gms_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    t_cmd    cmd;
    t_status status;

    gms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_last  (i_in_data.last_record),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    gms_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_data  (o_out_data),
        .o_out_valid (o_out_valid)
    );

endmodule
